>>> rtl/ppr_pkg.sv
package ppr_pkg;

	// Number of CORDIC micro-rotation cells in the chain (12 to 32).
	localparam int CORDIC_STAGES = 24;
	// Width of a cell's shift index; covers shifts 0..CORDIC_STAGES-1.
	localparam int STAGE_IDX_W = (CORDIC_STAGES > 16) ? 5 : 4;

	// Datapath width of the rotated vector, Q.40 with sign and growth headroom.
	localparam int XW = 46;
	// Fraction bits dropped when returning from Q.40 to Q2.29.
	localparam int FRAC_DROP = 11;
	// Prescale shift from Q.61 (Q2.29 times Q0.32) down to Q.40.
	localparam int PRESCALE_SHIFT = 21;

	// CORDIC limit gain 0.6072529350 in Q0.32, rounded down.
	localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
	// 1/(2*pi) in Q0.64, rounded down.
	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
	// Ratio 1.0 in Q8.24, used by field 0.
	localparam logic [31:0] RATIO_ONE = 32'h0100_0000;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSTEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASS_RATIO = 2'd2;

	// One vector in flight between CORDIC cells.
	typedef struct packed {
		logic                 valid;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [31:0]          z;
	} ppr_vec_t;

	// Arctangent of 2^-i in turns, rounded to 2^-32 turns.
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h2000_0000;
			5'd1:  a = 32'h12E4_051E;
			5'd2:  a = 32'h09FB_385B;
			5'd3:  a = 32'h0511_11D4;
			5'd4:  a = 32'h028B_0D43;
			5'd5:  a = 32'h0145_D7E1;
			5'd6:  a = 32'h00A2_F61E;
			5'd7:  a = 32'h0051_7C55;
			5'd8:  a = 32'h0028_BE53;
			5'd9:  a = 32'h0014_5F2F;
			5'd10: a = 32'h000A_2F98;
			5'd11: a = 32'h0005_17CC;
			5'd12: a = 32'h0002_8BE6;
			5'd13: a = 32'h0001_45F3;
			5'd14: a = 32'h0000_A2FA;
			5'd15: a = 32'h0000_517D;
			5'd16: a = 32'h0000_28BE;
			5'd17: a = 32'h0000_145F;
			5'd18: a = 32'h0000_0A30;
			5'd19: a = 32'h0000_0518;
			5'd20: a = 32'h0000_028C;
			5'd21: a = 32'h0000_0146;
			5'd22: a = 32'h0000_00A3;
			5'd23: a = 32'h0000_0051;
			5'd24: a = 32'h0000_0029;
			5'd25: a = 32'h0000_0014;
			5'd26: a = 32'h0000_000A;
			5'd27: a = 32'h0000_0005;
			5'd28: a = 32'h0000_0003;
			5'd29: a = 32'h0000_0001;
			5'd30: a = 32'h0000_0001;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/ppr_angle.sv
module ppr_angle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         re_in,
	input  logic [31:0]         im_in,
	input  logic [31:0]         potential,
	input  logic                field_select,
	input  logic [31:0]         time_step,
	input  logic [31:0]         substep_coeff,
	input  logic [31:0]         mass_ratio_1,
	output ppr_pkg::ppr_vec_t   vec_out
);

	localparam int XW = ppr_pkg::XW;

	// Stage valid flags, one per pipeline register.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	// Payload registers.
	logic [31:0] re_s1, im_s1, phi_s1;
	logic        sel_s1;

	logic [62:0]          k_s2;
	logic [31:0]          r_s2, mphi_s2;
	logic                 neg_s2;
	logic signed [XW-1:0] x_s2, y_s2;

	logic [63:0]          pplo_s3;
	logic [62:0]          pphi_s3;
	logic [31:0]          mphi_s3;
	logic                 neg_s3;
	logic signed [XW-1:0] x_s3, y_s3;

	logic [45:0]          kr_s4;
	logic [31:0]          mphi_s4;
	logic                 neg_s4;
	logic signed [XW-1:0] x_s4, y_s4;

	logic [63:0]          qlo_s5;
	logic [45:0]          qhi_s5;
	logic                 neg_s5;
	logic signed [XW-1:0] x_s5, y_s5;

	logic [61:0]          t3_s6;
	logic                 neg_s6;
	logic signed [XW-1:0] x_s6, y_s6;

	logic [63:0]          a0b0_s7, a0b1_s7;
	logic [61:0]          a1b0_s7, a1b1_s7;
	logic                 neg_s7;
	logic signed [XW-1:0] x_s7, y_s7;

	logic [63:0]          a0b0_s8;
	logic [64:0]          mid_s8;
	logic [61:0]          a1b1_s8;
	logic                 neg_s8;
	logic signed [XW-1:0] x_s8, y_s8;

	logic [31:0]          z_s9;
	logic                 neg_s9;
	logic signed [XW-1:0] x_s9, y_s9;

	logic signed [XW-1:0] x_s10, y_s10;
	logic [31:0]          z_s10;

	// Combinational terms of each stage.
	logic [31:0]          mda, mphi;
	logic signed [64:0]   xp, yp;
	logic [95:0]          kr_sum;
	logic [77:0]          q_sum;
	logic [64:0]          low_sum;
	logic [63:0]          h_sum;
	logic [31:0]          z_signed, z_quad;
	logic                 flip;

	always_comb begin
		mda  = substep_coeff[31] ? (~substep_coeff + 32'd1) : substep_coeff;
		mphi = phi_s1[31] ? (~phi_s1 + 32'd1) : phi_s1;
		xp   = $signed(re_s1) * $signed({1'b0, ppr_pkg::GAIN_Q32});
		yp   = $signed(im_s1) * $signed({1'b0, ppr_pkg::GAIN_Q32});
		kr_sum  = {1'b0, pphi_s3, 32'd0} + {32'd0, pplo_s3};
		q_sum   = {qhi_s5, 32'd0} + {14'd0, qlo_s5};
		low_sum = {1'b0, a0b0_s8} + {1'b0, mid_s8[31:0], 32'd0};
		h_sum   = {2'd0, a1b1_s8} + {31'd0, mid_s8[64:32]} + {63'd0, low_sum[64]};
		z_signed = neg_s9 ? (32'd0 - z_s9) : z_s9;
		z_quad   = z_signed + ppr_pkg::QUARTER_TURN;
		flip     = z_quad[31];
	end

	// Valid flags advance with the pipeline enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <=
				{in_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9};
		end
	end

	// Angle product chain of 32x32 partial products and the sums that join
	// them, followed by the half-turn fold ahead of the CORDIC cells.
	always_ff @(posedge clk) begin
		if (en) begin
			re_s1  <= re_in;
			im_s1  <= im_in;
			phi_s1 <= potential;
			sel_s1 <= field_select;

			k_s2    <= {31'd0, time_step} * {31'd0, mda};
			r_s2    <= sel_s1 ? mass_ratio_1 : ppr_pkg::RATIO_ONE;
			mphi_s2 <= mphi;
			neg_s2  <= (substep_coeff[31] == phi_s1[31]);
			x_s2    <= XW'(xp >>> ppr_pkg::PRESCALE_SHIFT);
			y_s2    <= XW'(yp >>> ppr_pkg::PRESCALE_SHIFT);

			pplo_s3 <= k_s2[31:0] * r_s2;
			pphi_s3 <= {32'd0, k_s2[62:32]} * {31'd0, r_s2};
			mphi_s3 <= mphi_s2;
			neg_s3  <= neg_s2;
			x_s3    <= x_s2;
			y_s3    <= y_s2;

			kr_s4   <= kr_sum[94:49];
			mphi_s4 <= mphi_s3;
			neg_s4  <= neg_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;

			qlo_s5 <= kr_s4[31:0] * mphi_s4;
			qhi_s5 <= {32'd0, kr_s4[45:32]} * {14'd0, mphi_s4};
			neg_s5 <= neg_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;

			t3_s6  <= q_sum[76:15];
			neg_s6 <= neg_s5;
			x_s6   <= x_s5;
			y_s6   <= y_s5;

			a0b0_s7 <= t3_s6[31:0] * ppr_pkg::INV_TWO_PI_Q64[31:0];
			a0b1_s7 <= t3_s6[31:0] * ppr_pkg::INV_TWO_PI_Q64[63:32];
			a1b0_s7 <= {32'd0, t3_s6[61:32]} * {30'd0, ppr_pkg::INV_TWO_PI_Q64[31:0]};
			a1b1_s7 <= {32'd0, t3_s6[61:32]} * {30'd0, ppr_pkg::INV_TWO_PI_Q64[63:32]};
			neg_s7  <= neg_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;

			a0b0_s8 <= a0b0_s7;
			mid_s8  <= {1'b0, a0b1_s7} + {3'd0, a1b0_s7};
			a1b1_s8 <= a1b1_s7;
			neg_s8  <= neg_s7;
			x_s8    <= x_s7;
			y_s8    <= y_s7;

			// Turns are fraction bits 103..72 of the full product.
			z_s9   <= h_sum[39:8];
			neg_s9 <= neg_s8;
			x_s9   <= x_s8;
			y_s9   <= y_s8;

			// Second and third quadrant: negate the vector, shift by half a turn.
			x_s10 <= flip ? -x_s9 : x_s9;
			y_s10 <= flip ? -y_s9 : y_s9;
			z_s10 <= flip ? (z_signed + ppr_pkg::HALF_TURN) : z_signed;
		end
	end

	assign vec_out = '{valid: v_s10, x: x_s10, y: y_s10, z: z_s10};

endmodule

>>> rtl/ppr_cordic_cell.sv
module ppr_cordic_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [ppr_pkg::STAGE_IDX_W-1:0]     shift,
	input  logic [31:0]                         atan,
	input  ppr_pkg::ppr_vec_t                   vec_in,
	output ppr_pkg::ppr_vec_t                   vec_out
);

	localparam int XW = ppr_pkg::XW;

	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	logic [31:0]          z_q;
	logic signed [XW-1:0] xs, ys;

	// One micro-rotation; the sign of the residual angle picks the direction.
	always_comb begin
		xs = vec_in.x >>> shift;
		ys = vec_in.y >>> shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vec_in.z[31]) begin
				x_q <= vec_in.x + ys;
				y_q <= vec_in.y - xs;
				z_q <= vec_in.z + atan;
			end else begin
				x_q <= vec_in.x - ys;
				y_q <= vec_in.y + xs;
				z_q <= vec_in.z - atan;
			end
		end
	end

	assign vec_out = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule

>>> rtl/potential_phase_rotator.sv
// Potential phase rotator: each beat on s_axis is one grid point, and the
// field value (re, im) leaves on m_axis rotated by the phase
// -(time_step * substep_coeff * ratio * potential), ratio being 1.0 for field 0
// and mass_ratio_1 for field 1. One beat is taken every clock cycle while the
// skid register is empty. From input beat to output beat, ten stages form the
// angle from 32x32 partial products and fold it to the right half plane, then
// come one register per CORDIC cell and the rounding, saturating output
// register. A skid register behind the output keeps the pipeline moving for
// one beat of back pressure; s_axis_tready drops only while that skid
// register is full. Configuration writes are always accepted and should be
// made only while no beat is in flight.
module potential_phase_rotator (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ppr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	// Input stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [95:0]                     s_axis_tdata,  // re_in, im_in, potential
	input  logic                            s_axis_tuser,  // field_select
	// Output stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [63:0]                     m_axis_tdata   // re_out, im_out
);

	localparam int XW = ppr_pkg::XW;
	localparam int RW = XW - ppr_pkg::FRAC_DROP;

	logic [31:0] time_step_q, substep_coeff_q, mass_ratio_1_q;
	logic        en;
	logic        skid_valid_q;
	logic [63:0] skid_data_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic        push;
	logic [63:0] result;

	logic signed [XW-1:0] xr_full, yr_full;
	logic signed [RW-1:0] xr, yr;
	logic [31:0]          x_sat, y_sat;

	ppr_pkg::ppr_vec_t chain [0:ppr_pkg::CORDIC_STAGES];

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q     <= '0;
			substep_coeff_q <= '0;
			mass_ratio_1_q  <= ppr_pkg::RATIO_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppr_pkg::REG_TIME_STEP:  time_step_q     <= cfg_data;
				ppr_pkg::REG_SUBSTEP:    substep_coeff_q <= cfg_data;
				ppr_pkg::REG_MASS_RATIO: mass_ratio_1_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves while the skid register is empty.
	assign en            = !skid_valid_q;
	assign s_axis_tready = !skid_valid_q;

	ppr_angle u_angle (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_axis_tvalid),
		.re_in         (s_axis_tdata[31:0]),
		.im_in         (s_axis_tdata[63:32]),
		.potential     (s_axis_tdata[95:64]),
		.field_select  (s_axis_tuser),
		.time_step     (time_step_q),
		.substep_coeff (substep_coeff_q),
		.mass_ratio_1  (mass_ratio_1_q),
		.vec_out       (chain[0])
	);

	// Chain of micro-rotation cells.
	for (genvar g = 0; g < ppr_pkg::CORDIC_STAGES; g++) begin : g_cell
		ppr_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.shift   (ppr_pkg::STAGE_IDX_W'(g)),
			.atan    (ppr_pkg::atan_turns(5'(g))),
			.vec_in  (chain[g]),
			.vec_out (chain[g+1])
		);
	end

	// Round to nearest, ties up, back to Q2.29 and saturate.
	always_comb begin
		xr_full = chain[ppr_pkg::CORDIC_STAGES].x + XW'(1 << (ppr_pkg::FRAC_DROP - 1));
		yr_full = chain[ppr_pkg::CORDIC_STAGES].y + XW'(1 << (ppr_pkg::FRAC_DROP - 1));
		xr = RW'(xr_full >>> ppr_pkg::FRAC_DROP);
		yr = RW'(yr_full >>> ppr_pkg::FRAC_DROP);
		if (xr[RW-1:31] == '0 || xr[RW-1:31] == '1) begin
			x_sat = xr[31:0];
		end else begin
			x_sat = xr[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if (yr[RW-1:31] == '0 || yr[RW-1:31] == '1) begin
			y_sat = yr[31:0];
		end else begin
			y_sat = yr[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		result = {y_sat, x_sat};
	end

	assign push = en && chain[ppr_pkg::CORDIC_STAGES].valid;

	// Output register with a one-beat skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : result;
		end else if (push) begin
			skid_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A held beat in the skid register always has one ahead of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// The skid register fills only behind a stalled output beat.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid register filled without back pressure");

	// A taken output beat drains the skid register at once.
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_axis_tready) |=> !skid_valid_q)
		else $error("skid register did not drain");

endmodule

>>> sim/potential_phase_rotator_tb.sv
`timescale 1ns / 100ps

module potential_phase_rotator_tb;

	// Arctangent of 2^-i in turns, rounded to 2^-32 turns.
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
		32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
		32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
	};
	localparam logic [63:0] TURNS_PER_RADIAN = 64'h28BE_60DB_9391_054A;
	localparam logic [31:0] CORDIC_GAIN      = 32'h9B74_EDA8;
	localparam logic [31:0] UNIT_RATIO       = 32'h0100_0000;
	// Index past the register list; the block must ignore it.
	localparam logic [ppr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// Angle stages, CORDIC cells, output register and some margin.
	localparam int DRAIN_CYCLES = 11 + ppr_pkg::CORDIC_STAGES + 12;
	localparam int ITEMS_PER_PHASE = 300;

	// Keeps a copy of the registers and the rotated points still owed by the block.
	class phase_scoreboard;
		logic [31:0] time_step;
		logic [31:0] substep_coeff;
		logic [31:0] mass_ratio_1;
		logic [63:0] rotated_q[$];
		int          errors;

		function new();
			time_step     = '0;
			substep_coeff = '0;
			mass_ratio_1  = UNIT_RATIO;
			errors        = 0;
		endfunction

		function void set_reg(logic [ppr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				ppr_pkg::REG_TIME_STEP:  time_step = val;
				ppr_pkg::REG_SUBSTEP:    substep_coeff = val;
				ppr_pkg::REG_MASS_RATIO: mass_ratio_1 = val;
				default: ;
			endcase
		endfunction

		// Phase -(dt * d_alpha * ratio * potential) as a binary angle in turns.
		function logic [31:0] phase_turns(logic [31:0] pot, logic fs);
			logic [31:0]  coef_mag;
			logic [31:0]  pot_mag;
			logic [31:0]  ratio;
			logic [63:0]  acc;
			logic [127:0] wide;
			logic [31:0]  z;
			coef_mag = substep_coeff[31] ? -substep_coeff : substep_coeff;
			pot_mag  = pot[31] ? -pot : pot;
			ratio    = fs ? mass_ratio_1 : UNIT_RATIO;
			acc  = {32'b0, time_step} * {32'b0, coef_mag};
			wide = {64'b0, acc} * {96'b0, ratio};
			acc  = wide[112:49];
			wide = {64'b0, acc} * {96'b0, pot_mag};
			acc  = wide[78:15];
			wide = {64'b0, acc} * {64'b0, TURNS_PER_RADIAN};
			z    = wide[103:72];
			if (substep_coeff[31] == pot[31])
				z = -z;
			return z;
		endfunction

		function logic [31:0] clamp_q29(logic signed [63:0] v);
			if (v > 64'sh7FFF_FFFF)
				return 32'h7FFF_FFFF;
			if (v < $signed(64'hFFFF_FFFF_8000_0000))
				return 32'h8000_0000;
			return v[31:0];
		endfunction

		// Gain-compensated CORDIC rotation of one grid point.
		function logic [63:0] rotate_point(logic [31:0] re, im, pot, logic fs);
			logic signed [63:0] x, y, xs, ys;
			logic [31:0]        z;
			logic [31:0]        zq;
			int                 i;
			z = phase_turns(pot, fs);
			x = $signed({{32{re[31]}}, re}) * $signed({32'b0, CORDIC_GAIN});
			y = $signed({{32{im[31]}}, im}) * $signed({32'b0, CORDIC_GAIN});
			x = x >>> 21;
			y = y >>> 21;
			// Fold the left half plane over by half a turn.
			zq = z + ppr_pkg::QUARTER_TURN;
			if (zq[31]) begin
				x = -x;
				y = -y;
				z = z + ppr_pkg::HALF_TURN;
			end
			for (i = 0; i < ppr_pkg::CORDIC_STAGES && i < 32; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z[31]) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_TAB[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_TAB[i];
				end
			end
			x = (x + 64'sd1024) >>> 11;
			y = (y + 64'sd1024) >>> 11;
			return {clamp_q29(y), clamp_q29(x)};
		endfunction

		function void note_point(logic [95:0] data, logic fs);
			rotated_q.push_back(rotate_point(data[31:0], data[63:32], data[95:64], fs));
		endfunction

		function void check_rotation(logic [63:0] got);
			logic [63:0] want;
			if (rotated_q.size() == 0) begin
				$display("%0t: output beat %h with no point outstanding", $time, got);
				errors++;
				return;
			end
			want = rotated_q.pop_front();
			if (got[31:0] !== want[31:0]) begin
				$display("%0t: re_out expected %h got %h", $time, want[31:0], got[31:0]);
				errors++;
			end
			if (got[63:32] !== want[63:32]) begin
				$display("%0t: im_out expected %h got %h", $time, want[63:32], got[63:32]);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                   cfg_data;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [95:0]                   s_axis_tdata;   // re_in, im_in, potential
	logic                          s_axis_tuser;   // field_select
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [63:0]                   m_axis_tdata;   // re_out, im_out

	phase_scoreboard sb;
	bit              idle_on = 1'b1;
	bit              sink_hold_req = 1'b0;

	potential_phase_rotator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watch all three channels and keep the scoreboard in step.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_point(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_rotation(m_axis_tdata);
		end
	end

	// Output side: short random stalls, plus one long hold-off on request.
	initial begin : sink
		int unsigned stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				stall_left = 199;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// One register write; cfg_valid drops again before the task returns.
	task automatic write_reg(input logic [ppr_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [31:0] dt, coef, ratio);
		write_reg(ppr_pkg::REG_TIME_STEP, dt);
		write_reg(ppr_pkg::REG_SUBSTEP, coef);
		write_reg(ppr_pkg::REG_MASS_RATIO, ratio);
	endtask

	// Offer one grid point and hold it until the block takes the beat.
	task automatic send_point(input logic [31:0] re, im, pot, input logic fs);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pot, im, re};
		s_axis_tuser  <= fs;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Let every outstanding point come out, then give the pipeline time to empty.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.rotated_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int          ph;
		int          n;
		logic [31:0] pot;
		sb = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers give a zero angle: the CORDIC still runs.
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		settle();

		// Unit dt and coefficient, ratio two; angles on and near the quadrant edges.
		load_regs(32'h1000_0000, 32'h2000_0000, 32'h0200_0000);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0064_87ED, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0064_87ED, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'hFF9B_7813, 1'b0);
		send_point(32'h2000_0000, 32'h0000_0000, 32'h00C9_0FDB, 1'b0);
		send_point(32'h2000_0000, 32'h1000_0000, 32'h0192_1FB5, 1'b0);
		send_point(32'h0000_0000, 32'h8000_0000, 32'h025B_2F8F, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h0000_0000, 32'hFF36_F025, 1'b0);
		send_point(32'h0000_0000, 32'h7FFF_FFFF, 32'hFE6D_E04B, 1'b1);
		send_point(32'h1234_5678, 32'hEDCB_A987, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h1234_5678, 32'hEDCB_A987, 32'h8000_0000, 1'b1);
		settle();

		// Largest register magnitudes, with potentials of largest and smallest magnitude.
		load_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_point($urandom, $urandom, 32'h7FFF_FFFF, 1'b1);
		send_point($urandom, $urandom, 32'h8000_0000, 1'b1);
		send_point($urandom, $urandom, 32'h0000_0001, 1'b0);
		send_point($urandom, $urandom, 32'hFFFF_FFFF, 1'b1);
		settle();
		write_reg(ppr_pkg::REG_SUBSTEP, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		settle();

		// Random phases: two at the register extremes, the rest random.
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
				1: load_regs(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
				default: load_regs(rand_word(), rand_word(), rand_word());
			endcase
			if (ph == 5)
				idle_on = 1'b0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 2 && n == 60)
					sink_hold_req = 1'b1;
				pot = rand_word();
				if ($urandom_range(0, 3) == 0)
					pot = {{9{pot[31]}}, pot[22:0]};
				send_point(rand_word(), rand_word(), pot, 1'($urandom_range(0, 1)));
			end
			settle();
		end

		if (sb.errors == 0 && sb.rotated_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#200000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> potential_phase_rotator.f
rtl/ppr_pkg.sv
rtl/ppr_angle.sv
rtl/ppr_cordic_cell.sv
rtl/potential_phase_rotator.sv
sim/potential_phase_rotator_tb.sv
